// ----- rtl/core/slsc_pkg.sv -----
// shared types, register codes and constants of the stereo compressor
`default_nettype none

package slsc_pkg;

  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int LOG_TABLE_DEPTH_DEF = 256;

  // iteration counts of the multi-cycle units
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 29;
  localparam int GAIN_STEPS = 16;

  localparam logic [18:0]        DB_PER_LOG2   = 19'd394566;
  localparam logic [21:0]        LOG2_PER_DB   = 22'd2786635;
  localparam logic signed [16:0] ZERO_LEVEL_DB = -17'sd61440;
  localparam logic [20:0]        LOG2_OFFSET   = 21'd1507328;  // 23 in q16
  localparam logic [23:0]        UNITY_GAIN    = 24'd8388608;

  localparam logic signed [14:0] THRESHOLD_RST = -15'sd4608;
  localparam logic signed [15:0] SLOPE_RST     = -16'sd24576;
  localparam logic [12:0]        KNEE_RST      = 13'd1536;
  localparam logic [23:0]        ATTACK_RST    = 24'd16441671;
  localparam logic [23:0]        RELEASE_RST   = 24'd16774045;
  localparam logic [23:0]        RMS_RST       = 24'd16739206;
  localparam logic [23:0]        MAKEUP_RST    = 24'd1048576;
  localparam logic [1:0]         MODE_RST      = 2'd0;

  typedef enum logic [2:0] {
    REG_THRESHOLD,
    REG_SLOPE,
    REG_KNEE,
    REG_ATTACK,
    REG_RELEASE,
    REG_RMS,
    REG_MAKEUP,
    REG_MODE
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] threshold_db;
    logic signed [15:0] curve_slope;
    logic [12:0]        knee_width_db;
    logic [23:0]        attack_coef;
    logic [23:0]        release_coef;
    logic [23:0]        rms_coef;
    logic [23:0]        makeup_gain;
    logic [1:0]         detect_mode;
  } cfg_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_DET,
    ST_PK_SEL,
    ST_PK_M0,
    ST_PK_M1,
    ST_RM_SQ,
    ST_RM_H0,
    ST_RM_H1,
    ST_RM_L0,
    ST_RM_L1,
    ST_SQ_INIT,
    ST_SQ_STEP,
    ST_LV_INIT,
    ST_LV_NORM,
    ST_LG_POS,
    ST_LG_TAB,
    ST_LG_MUL,
    ST_LG_NEG,
    ST_LG_DB,
    ST_CV_OVER,
    ST_CV_CLASS,
    ST_KN_Q2,
    ST_KN_NUM,
    ST_DIV_STEP,
    ST_KN_RED,
    ST_HD,
    ST_GN_L,
    ST_GN_STEP,
    ST_GN_TGT,
    ST_SM_SEL,
    ST_SM_M0,
    ST_SM_M1,
    ST_MK,
    ST_SC_L,
    ST_SC_R,
    ST_OUT
  } st_t;

  typedef struct packed {
    st_t        op;
    logic [4:0] step;
    logic       load;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic rms_mode;
    logic norm_done;
    logic knee_case;
    logic hard_case;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/slsc_regs.sv -----
// configuration register file of the stereo compressor
`default_nettype none

module slsc_regs
  import slsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db  <= THRESHOLD_RST;
      cfg.curve_slope   <= SLOPE_RST;
      cfg.knee_width_db <= KNEE_RST;
      cfg.attack_coef   <= ATTACK_RST;
      cfg.release_coef  <= RELEASE_RST;
      cfg.rms_coef      <= RMS_RST;
      cfg.makeup_gain   <= MAKEUP_RST;
      cfg.detect_mode   <= MODE_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold_db  <= cfg_data[14:0];
        REG_SLOPE:     cfg.curve_slope   <= cfg_data[15:0];
        REG_KNEE:      cfg.knee_width_db <= cfg_data[12:0];
        REG_ATTACK:    cfg.attack_coef   <= cfg_data;
        REG_RELEASE:   cfg.release_coef  <= cfg_data;
        REG_RMS:       cfg.rms_coef      <= cfg_data;
        REG_MAKEUP:    cfg.makeup_gain   <= cfg_data;
        REG_MODE:      cfg.detect_mode   <= cfg_data[1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slsc_dp.sv -----
// datapath of the stereo compressor: shared multiplier, detector, log, curve and gain
`default_nettype none

module slsc_dp
  import slsc_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  input  wire cfg_t                   cfg,
  input  wire logic [SAMPLE_BITS-1:0] left_in,
  input  wire logic [SAMPLE_BITS-1:0] right_in,
  output logic [SAMPLE_BITS-1:0]      left_out,
  output logic [SAMPLE_BITS-1:0]      right_out,
  output logic [23:0]                 applied_gain,
  output stat_t                       stat
);

  localparam int SB = SAMPLE_BITS;
  localparam int IW = $clog2(LOG_TABLE_DEPTH + 1);

  typedef logic [16:0] log_tab_t [LOG_TABLE_DEPTH+1];
  typedef logic [29:0] root_tab_t [17];

  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [15:0] v;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      y = (64'd1 << 30) + ((64'(i)) << 30) / LOG_TABLE_DEPTH;
      v = '0;
      for (int b = 15; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          v[b] = 1'b1;
        end
      end
      t[i] = 17'(v);
    end
    t[LOG_TABLE_DEPTH] = 17'd65536;
    return t;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v0;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   r;
    logic [63:0] prev;
    prev = 64'd1 << 29;
    r[0] = 30'(prev);
    for (int k = 1; k <= 16; k++) begin
      prev = isqrt64(prev << 30);
      r[k] = 30'(prev);
    end
    return r;
  endfunction

  localparam log_tab_t  LOG2_TAB   = build_log_tab();
  localparam root_tab_t HALF_ROOTS = build_roots();

  // saturates the rounded, scaled magnitude and restores its sign as a signed sample
  function automatic logic [SB-1:0] sat_out(input logic [37:0] r, input logic neg);
    logic [37:0] lim;
    logic [37:0] m;
    lim = 38'd1 << (SB - 1);
    if (neg) begin
      m = (r > lim) ? lim : r;
      m = ~m + 38'd1;
    end else begin
      m = (r > lim - 38'd1) ? lim - 38'd1 : r;
    end
    return m[SB-1:0];
  endfunction

  logic [SB-1:0]        xl, xr;
  logic [23:0]          det, csel, pe, sg, target;
  logic [48:0]          acc;
  logic [47:0]          ms, sq, hi, sv, res;
  logic [23:0]          norm;
  logic [4:0]           e;
  logic                 lv_zero;
  logic [IW-1:0]        idx;
  logic [22:0]          rr;
  logic [16:0]          t0, tdiff, lg;
  logic [20:0]          neg;
  logic signed [16:0]   level;
  logic signed [17:0]   over;
  logic [14:0]          q;
  logic [29:0]          q2;
  logic [28:0]          dq;
  logic [12:0]          rem;
  logic [16:0]          red;
  logic [7:0]           nsh;
  logic [15:0]          ff;
  logic [30:0]          g;
  logic [27:0]          gm;
  logic [SB-1:0]        ol, orr;

  logic [SB-1:0]        mag_l, mag_r, det_sel;
  logic [SB+23:0]       det_wide;
  logic [24:0]          cm, dr;
  logic [15:0]          sm;
  logic [31:0]          mul_a;
  logic [29:0]          mul_b;
  logic [61:0]          prod;
  logic [49:0]          mac;
  logic [47:0]          bitv, trial;
  logic [13:0]          rem_sh;
  logic [46:0]          num;
  logic [40:0]          db_sum;
  logic [39:0]          l_sum;
  logic [61:0]          g_sum;
  logic [30:0]          g_sh;
  logic [31:0]          g_rnd;
  logic [48:0]          mk_sum;
  logic [60:0]          sc_sum;
  logic [32:0]          hd_sum;
  logic signed [18:0]   over2, knee_s;
  logic [23:0]          lv_src;
  logic [IW-1:0]        idx_p1;

  assign mag_l    = xl[SB-1] ? (~xl + 1'b1) : xl;
  assign mag_r    = xr[SB-1] ? (~xr + 1'b1) : xr;
  assign det_sel  = (cfg.detect_mode[1] || mag_l >= mag_r) ? mag_l : mag_r;
  assign det_wide = {det_sel, 24'd0} >> SB;
  assign cm       = 25'h1000000 - {1'b0, csel};
  assign dr       = 25'h1000000 - {1'b0, cfg.rms_coef};
  assign sm       = 16'(-cfg.curve_slope);
  assign over2    = {over, 1'b0};
  assign knee_s   = {6'd0, cfg.knee_width_db};
  assign lv_src   = cfg.detect_mode[0] ? res[23:0] : pe;
  assign idx_p1   = idx + 1'b1;
  assign bitv     = 48'd1 << (6'd46 - {cmd.step, 1'b0});
  assign trial    = res + bitv;
  assign rem_sh   = {rem, dq[28]};

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ST_PK_M0:   begin mul_a = 32'(csel);          mul_b = 30'(pe);            end
      ST_PK_M1:   begin mul_a = 32'(cm);            mul_b = 30'(det);           end
      ST_RM_SQ:   begin mul_a = 32'(det);           mul_b = 30'(det);           end
      ST_RM_H0:   begin mul_a = 32'(cfg.rms_coef);  mul_b = 30'(ms[47:24]);     end
      ST_RM_H1:   begin mul_a = 32'(dr);            mul_b = 30'(sq[47:24]);     end
      ST_RM_L0:   begin mul_a = 32'(cfg.rms_coef);  mul_b = 30'(ms[23:0]);      end
      ST_RM_L1:   begin mul_a = 32'(dr);            mul_b = 30'(sq[23:0]);      end
      ST_LG_POS:  begin mul_a = 32'(norm[22:0]);    mul_b = 30'(LOG_TABLE_DEPTH); end
      ST_LG_MUL:  begin mul_a = 32'(rr);            mul_b = 30'(tdiff);         end
      ST_LG_DB:   begin mul_a = 32'(neg);           mul_b = 30'(DB_PER_LOG2);   end
      ST_KN_Q2:   begin mul_a = 32'(q);             mul_b = 30'(q);             end
      ST_KN_NUM:  begin mul_a = 32'(q2);            mul_b = 30'(sm);            end
      ST_HD:      begin mul_a = 32'(over[16:0]);    mul_b = 30'(sm);            end
      ST_GN_L:    begin mul_a = 32'(red);           mul_b = 30'(LOG2_PER_DB);   end
      ST_GN_STEP: begin mul_a = 32'(g);             mul_b = HALF_ROOTS[5'(cmd.step + 1'b1)]; end
      ST_SM_M0:   begin mul_a = 32'(csel);          mul_b = 30'(sg);            end
      ST_SM_M1:   begin mul_a = 32'(cm);            mul_b = 30'(target);        end
      ST_MK:      begin mul_a = 32'(sg);            mul_b = 30'(cfg.makeup_gain); end
      ST_SC_L:    begin mul_a = 32'(mag_l);         mul_b = 30'(gm);            end
      ST_SC_R:    begin mul_a = 32'(mag_r);         mul_b = 30'(gm);            end
      default:    ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign mac    = {1'b0, acc} + {1'b0, prod[48:0]};
  assign num    = {1'b0, prod[45:0]} + {17'd0, cfg.knee_width_db, 17'd0};
  assign db_sum = {1'b0, prod[39:0]} + 41'd8388608;
  assign l_sum  = {1'b0, prod[38:0]} + 40'd32768;
  assign g_sum  = {1'b0, prod[60:0]} + (62'd1 << 29);
  assign g_sh   = g >> nsh[4:0];
  assign g_rnd  = {1'b0, g_sh} + 32'd64;
  assign mk_sum = {1'b0, prod[47:0]} + 49'd524288;
  assign sc_sum = prod[60:0] + 61'd4194304;
  assign hd_sum = prod[32:0] + 33'd16384;

  always_ff @(posedge clk) begin
    if (rst) begin
      pe <= '0;
      ms <= '0;
      sg <= UNITY_GAIN;
    end else begin
      if (cmd.load) begin
        xl <= left_in;
        xr <= right_in;
      end
      if (cmd.commit) begin
        left_out     <= ol;
        right_out    <= orr;
        applied_gain <= sg;
      end
      case (cmd.op)
        ST_DET:     det  <= det_wide[23:0];
        ST_PK_SEL:  csel <= (det > pe) ? cfg.attack_coef : cfg.release_coef;
        ST_PK_M0:   acc  <= prod[48:0];
        ST_PK_M1:   pe   <= mac[47:24];
        ST_RM_SQ:   sq   <= prod[47:0];
        ST_RM_H0:   acc  <= prod[48:0];
        ST_RM_H1:   hi   <= mac[47:0];
        ST_RM_L0:   acc  <= prod[48:0];
        ST_RM_L1:   ms   <= hi + {22'd0, mac[49:24]};
        ST_SQ_INIT: begin
          sv  <= ms;
          res <= '0;
        end
        ST_SQ_STEP: begin
          if (sv >= trial) begin
            sv  <= sv - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
        end
        ST_LV_INIT: begin
          norm    <= lv_src;
          e       <= 5'd23;
          lv_zero <= (lv_src == '0);
        end
        ST_LV_NORM: begin
          if (!norm[23] && e != '0) begin
            norm <= norm << 1;
            e    <= e - 1'b1;
          end
        end
        ST_LG_POS: begin
          idx <= prod[23+IW-1:23];
          rr  <= prod[22:0];
        end
        ST_LG_TAB: begin
          t0    <= LOG2_TAB[idx];
          tdiff <= LOG2_TAB[idx_p1] - LOG2_TAB[idx];
        end
        ST_LG_MUL:  lg  <= t0 + prod[39:23];
        ST_LG_NEG:  neg <= LOG2_OFFSET - ({e, 16'd0} + {4'd0, lg});
        ST_LG_DB:   level <= lv_zero ? ZERO_LEVEL_DB : -$signed({1'b0, db_sum[39:24]});
        ST_CV_OVER: over  <= 18'(level) - 18'(cfg.threshold_db);
        ST_CV_CLASS: begin
          q   <= 15'(over2 + knee_s);
          red <= '0;
        end
        ST_KN_Q2:   q2 <= prod[29:0];
        ST_KN_NUM: begin
          dq  <= num[46:18];
          rem <= '0;
        end
        ST_DIV_STEP: begin
          if (rem_sh >= {1'b0, cfg.knee_width_db}) begin
            rem <= 13'(rem_sh - {1'b0, cfg.knee_width_db});
            dq  <= {dq[27:0], 1'b1};
          end else begin
            rem <= rem_sh[12:0];
            dq  <= {dq[27:0], 1'b0};
          end
        end
        ST_KN_RED:  red <= dq[16:0];
        ST_HD:      red <= hd_sum[31:15];
        ST_GN_L: begin
          nsh <= l_sum[39:32];
          ff  <= l_sum[31:16];
          g   <= 31'd1 << 30;
        end
        ST_GN_STEP: begin
          if (ff[4'd15 - cmd.step[3:0]]) g <= g_sum[60:30];
        end
        ST_GN_TGT:  target <= (nsh >= 8'd31) ? 24'd0 : g_rnd[30:7];
        ST_SM_SEL:  csel <= (target < sg) ? cfg.attack_coef : cfg.release_coef;
        ST_SM_M0:   acc  <= prod[48:0];
        ST_SM_M1:   sg   <= mac[47:24];
        ST_MK:      gm   <= mk_sum[47:20];
        ST_SC_L:    ol   <= sat_out(sc_sum[60:23], xl[SB-1]);
        ST_SC_R:    orr  <= sat_out(sc_sum[60:23], xr[SB-1]);
        default:    ;
      endcase
    end
  end

  assign stat.rms_mode  = cfg.detect_mode[0];
  assign stat.norm_done = norm[23] || (e == '0);
  assign stat.knee_case = cfg.curve_slope[15] && (cfg.knee_width_db != '0) &&
                          (over2 >= -knee_s) && (over2 <= knee_s);
  assign stat.hard_case = cfg.curve_slope[15] && !stat.knee_case &&
                          !over[17] && (over != '0);

endmodule

`default_nettype wire

// ----- rtl/core/slsc_ctrl.sv -----
// sequencer of the stereo compressor datapath
`default_nettype none

module slsc_ctrl
  import slsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_valid,
  output logic       s_ready,
  output logic       m_valid,
  input  wire logic  m_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  st_t        state, state_next;
  logic [4:0] step, step_next;
  logic       out_valid, out_valid_next;

  always_comb begin
    state_next = state;
    step_next  = '0;
    unique case (state)
      ST_IDLE:     if (s_valid) state_next = ST_DET;
      ST_DET:      state_next = stat.rms_mode ? ST_RM_SQ : ST_PK_SEL;
      ST_PK_SEL:   state_next = ST_PK_M0;
      ST_PK_M0:    state_next = ST_PK_M1;
      ST_PK_M1:    state_next = ST_LV_INIT;
      ST_RM_SQ:    state_next = ST_RM_H0;
      ST_RM_H0:    state_next = ST_RM_H1;
      ST_RM_H1:    state_next = ST_RM_L0;
      ST_RM_L0:    state_next = ST_RM_L1;
      ST_RM_L1:    state_next = ST_SQ_INIT;
      ST_SQ_INIT:  state_next = ST_SQ_STEP;
      ST_SQ_STEP: begin
        if (step == 5'(SQRT_STEPS - 1)) state_next = ST_LV_INIT;
        else step_next = step + 1'b1;
      end
      ST_LV_INIT:  state_next = ST_LV_NORM;
      ST_LV_NORM:  if (stat.norm_done) state_next = ST_LG_POS;
      ST_LG_POS:   state_next = ST_LG_TAB;
      ST_LG_TAB:   state_next = ST_LG_MUL;
      ST_LG_MUL:   state_next = ST_LG_NEG;
      ST_LG_NEG:   state_next = ST_LG_DB;
      ST_LG_DB:    state_next = ST_CV_OVER;
      ST_CV_OVER:  state_next = ST_CV_CLASS;
      ST_CV_CLASS: begin
        if (stat.knee_case) state_next = ST_KN_Q2;
        else if (stat.hard_case) state_next = ST_HD;
        else state_next = ST_GN_L;
      end
      ST_KN_Q2:    state_next = ST_KN_NUM;
      ST_KN_NUM:   state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (step == 5'(DIV_STEPS - 1)) state_next = ST_KN_RED;
        else step_next = step + 1'b1;
      end
      ST_KN_RED:   state_next = ST_GN_L;
      ST_HD:       state_next = ST_GN_L;
      ST_GN_L:     state_next = ST_GN_STEP;
      ST_GN_STEP: begin
        if (step == 5'(GAIN_STEPS - 1)) state_next = ST_GN_TGT;
        else step_next = step + 1'b1;
      end
      ST_GN_TGT:   state_next = ST_SM_SEL;
      ST_SM_SEL:   state_next = ST_SM_M0;
      ST_SM_M0:    state_next = ST_SM_M1;
      ST_SM_M1:    state_next = ST_MK;
      ST_MK:       state_next = ST_SC_L;
      ST_SC_L:     state_next = ST_SC_R;
      ST_SC_R:     state_next = ST_OUT;
      ST_OUT:      if (!out_valid || m_ready) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = state;
    cmd.step   = step;
    cmd.load   = (state == ST_IDLE) && s_valid;
    cmd.commit = (state == ST_OUT) && (!out_valid || m_ready);
    s_ready    = (state == ST_IDLE);
    m_valid    = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (m_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result register not marked valid after commit");

  a_load_starts_detect: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DET) && !s_ready)
    else $error("accepted sample did not start the detector");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ_STEP || state == ST_DIV_STEP || state == ST_GN_STEP)
      |-> step < 5'(DIV_STEPS))
    else $error("iteration counter ran past its loop");

  a_commit_only_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_ready && state == ST_OUT) |=> state == ST_OUT)
    else $error("result overwritten while still pending");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/stereo_linked_soft_knee_compressor.sv -----
// top level of the stereo-linked feed-forward soft-knee compressor
// each input transaction passes through the states of the sequencer in order:
//   detector (peak, or rms with a 24-step root), level normalize,
//   knee divide (in the knee; a direct product above it), 16-step gain build, smoothing and scaling
// a new sample pair is taken only after the last result is committed; an unread result holds the next one back
// reset: synchronous, restores register defaults, clears envelopes and sets unity gain
`default_nettype none

module stereo_linked_soft_knee_compressor
  import slsc_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // sample stream in
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // left_in, right_in
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // result stream out
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // left_out, right_out, applied_gain
  output logic [((2*SAMPLE_BITS+24+7)/8)*8-1:0]          m_axis_tdata,
  // register write channel
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [2:0]                                cfg_index,
  input  wire logic [23:0]                               cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((2*SAMPLE_BITS+24+7)/8)*8;

  cfg_t          cfg;
  cmd_t          cmd;
  stat_t         stat;
  logic [SB-1:0] left_out, right_out;
  logic [23:0]   applied_gain;

  // configuration registers, to be written only while the block is idle; the block does not enforce this
  slsc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: one datapath step per cycle unless stalled by an unread result; holds the result valid flag
  slsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: one shared multiplier, detector state, log and gain tables
  slsc_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .left_in      (s_axis_tdata[SB-1:0]),
    .right_in     (s_axis_tdata[2*SB-1:SB]),
    .left_out     (left_out),
    .right_out    (right_out),
    .applied_gain (applied_gain),
    .stat         (stat)
  );

  // pack result fields from the lowest bit up, pad with zeros
  assign m_axis_tdata = OUT_W'({applied_gain, right_out, left_out});

endmodule

`default_nettype wire
